>>> rtl/vietnamese_digraph_transcoder_top_defines.svh
// Assertion macros for the Vietnamese digraph transcoder.
// Used by the top level only; depends on a signal named clock and one named reset.
`ifndef VIETNAMESE_DIGRAPH_TRANSCODER_TOP_DEFINES_SVH
`define VIETNAMESE_DIGRAPH_TRANSCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/vdt_pkg.sv
// Shared types, constants and lookup functions of the Vietnamese digraph transcoder.
// No dependencies; imported by the decoder, the top level and the testbench.
package vdt_pkg;

   localparam logic [7:0] CharOne   = 8'h31;
   localparam logic [7:0] CharFive  = 8'h35;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharSix   = 8'h36;
   localparam logic [7:0] CharSeven = 8'h37;
   localparam logic [7:0] CharEight = 8'h38;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] ChLowA    = 8'h61;
   localparam logic [7:0] ChLowD    = 8'h64;
   localparam logic [7:0] ChLowE    = 8'h65;
   localparam logic [7:0] ChLowI    = 8'h69;
   localparam logic [7:0] ChLowO    = 8'h6f;
   localparam logic [7:0] ChLowU    = 8'h75;
   localparam logic [7:0] ChLowY    = 8'h79;
   localparam logic [7:0] ChUpD     = 8'h44;

   localparam logic [7:0] BaseA8 = 8'd128;
   localparam logic [7:0] BaseA6 = 8'd134;
   localparam logic [7:0] BaseE6 = 8'd140;
   localparam logic [7:0] BaseO7 = 8'd146;
   localparam logic [7:0] BaseO6 = 8'd152;
   localparam logic [7:0] BaseU7 = 8'd158;
   localparam logic [7:0] CodeD9 = 8'd249;
   localparam logic [7:0] CodeUpD9 = 8'd250;
   localparam logic [7:0] ToneA  = 8'd164;
   localparam logic [7:0] ToneE  = 8'd169;
   localparam logic [7:0] ToneU  = 8'd210;

   // Result queue geometry.
   localparam int QDepth = 4;
   localparam int PtrW   = $clog2(QDepth);
   localparam int CntW   = $clog2(QDepth + 1);

   typedef struct packed {
      logic       held_valid;
      logic [7:0] held_byte;
      logic       held_is_base;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic       last0;
      logic [7:0] byte1;
      logic       last1;
   } emit_type;

   function automatic logic is_base(input logic [7:0] b);
      return (b == BaseA8) || (b == BaseA6) || (b == BaseE6) ||
             (b == BaseO7) || (b == BaseO6) || (b == BaseU7);
   endfunction

   function automatic logic is_lead(input logic [7:0] b);
      return (b == ChLowA) || (b == ChLowE) || (b == ChLowI) || (b == ChLowO) ||
             (b == ChLowU) || (b == ChLowY) || (b == ChLowD) || (b == ChUpD);
   endfunction

   function automatic logic is_tone_digit(input logic [7:0] b);
      return (b >= CharOne) && (b <= CharFive);
   endfunction

   // Code of a lead letter followed by a digit, zero when the pair is not listed.
   function automatic logic [7:0] pair_code(input logic [7:0] letter,
                                            input logic [7:0] digit);
      logic [7:0] diff;
      logic [2:0] k;
      logic [7:0] code;
      diff = digit - CharOne;
      k    = diff[2:0];
      code = 8'd0;
      if (is_tone_digit(digit)) begin
         case (letter)
            ChLowA: code = ToneA + {5'd0, k};
            ChLowE: code = ToneE + {5'd0, k};
            ChLowU: code = ToneU + {5'd0, k};
            ChLowI: begin
               case (k)
                  3'd0: code = 8'd174;
                  3'd1: code = 8'd175;
                  3'd2: code = 8'd181;
                  3'd3: code = 8'd182;
                  default: code = 8'd183;
               endcase
            end
            ChLowO: begin
               case (k)
                  3'd0: code = 8'd184;
                  3'd1: code = 8'd190;
                  3'd2: code = 8'd198;
                  3'd3: code = 8'd199;
                  default: code = 8'd208;
               endcase
            end
            ChLowY: begin
               case (k)
                  3'd0: code = 8'd215;
                  3'd1: code = 8'd216;
                  3'd2: code = 8'd221;
                  3'd3: code = 8'd222;
                  default: code = 8'd248;
               endcase
            end
            default: code = 8'd0;
         endcase
      end
      if (letter == ChLowA && digit == CharEight) code = BaseA8;
      if (letter == ChLowA && digit == CharSix)   code = BaseA6;
      if (letter == ChLowE && digit == CharSix)   code = BaseE6;
      if (letter == ChLowO && digit == CharSeven) code = BaseO7;
      if (letter == ChLowO && digit == CharSix)   code = BaseO6;
      if (letter == ChLowU && digit == CharSeven) code = BaseU7;
      if (letter == ChLowD && digit == CharNine)  code = CodeD9;
      if (letter == ChUpD  && digit == CharNine)  code = CodeUpD9;
      return code;
   endfunction

endpackage

>>> rtl/vdt_decode.sv
// Per-byte decision of the transcoder: pending state plus one input byte give
// the next pending state and up to two result bytes. Depends on vdt_pkg.
module vdt_decode (
   input  vdt_pkg::state_type cur_state,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   output vdt_pkg::state_type next_state,
   output vdt_pkg::emit_type  emit
);
   import vdt_pkg::*;

   logic [7:0] code;
   logic [7:0] digit_val;

   assign code      = pair_code(cur_state.held_byte, in_byte);
   assign digit_val = in_byte - CharZero;

   always_comb begin
      logic       used;
      logic [1:0] n;
      logic [7:0] r0;
      logic [7:0] r1;
      logic       l0;
      logic       l1;
      state_type  ns;
      used = 1'b0;
      n    = 2'd0;
      r0   = 8'd0;
      r1   = 8'd0;
      l0   = 1'b0;
      l1   = 1'b0;
      ns   = cur_state;

      if (cur_state.held_valid) begin
         if (cur_state.held_is_base && is_tone_digit(in_byte)) begin
            r0 = cur_state.held_byte + digit_val;
            n  = 2'd1;
            ns.held_valid = 1'b0;
            used = 1'b1;
         end else if (!cur_state.held_is_base && code != 8'd0) begin
            // A pair that lands on a base code stays pending for a tone digit.
            if (is_base(code)) begin
               ns.held_byte    = code;
               ns.held_is_base = 1'b1;
            end else begin
               r0 = code;
               n  = 2'd1;
               ns.held_valid = 1'b0;
            end
            used = 1'b1;
         end else begin
            r0 = cur_state.held_byte;
            n  = 2'd1;
            ns.held_valid = 1'b0;
         end
      end

      if (!used) begin
         if (is_lead(in_byte)) begin
            ns.held_valid   = 1'b1;
            ns.held_byte    = in_byte;
            ns.held_is_base = 1'b0;
         end else if (is_base(in_byte)) begin
            ns.held_valid   = 1'b1;
            ns.held_byte    = in_byte;
            ns.held_is_base = 1'b1;
         end else begin
            if (n == 2'd0) r0 = in_byte;
            else           r1 = in_byte;
            n = n + 2'd1;
         end
      end

      if (in_last) begin
         if (ns.held_valid) begin
            if (n == 2'd0) r0 = ns.held_byte;
            else           r1 = ns.held_byte;
            n = n + 2'd1;
            ns.held_valid   = 1'b0;
            ns.held_is_base = 1'b0;
         end
         if (n == 2'd1) l0 = 1'b1;
         else           l1 = 1'b1;
      end

      next_state  = ns;
      emit.count  = n;
      emit.byte0  = r0;
      emit.last0  = l0;
      emit.byte1  = r1;
      emit.last1  = l1;
   end

endmodule

>>> rtl/vietnamese_digraph_transcoder_top.sv
// Vietnamese digraph transcoder: folds VNI letter-plus-digit pairs of a text
// byte stream into single code-page bytes.
//
// Input channel req_*: one text byte per word in req_tdata, req_tlast marks the
// final byte of a string and flushes any pending letter or base code.
// Result channel rsp_*: one code-page or plain byte per word in rsp_tdata,
// rsp_tlast on the final result byte of a string.
// Each accepted word is decoded in the cycle it is taken, against the one
// pending byte, and yields zero, one or two result words. Those are written
// into a four-entry result queue, so results are offered from registers.
// Throughput: one input word per cycle while results drain at least as fast
// as they are produced. req_tready drops when fewer than two queue entries
// would be free, so a stalled receiver backs up the input after at most a few
// words; nothing is lost or reordered.
// Reset clears the pending byte and empties the queue.
`include "vietnamese_digraph_transcoder_top_defines.svh"

module vietnamese_digraph_transcoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);
   import vdt_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   emit_type   emit;

   logic [7:0]      data_ff [QDepth];
   logic            last_ff [QDepth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic [PtrW-1:0] wr_ptr_next;

   logic req_accept;
   logic rsp_accept;
   logic last_accept;
   logic [1:0] push_n;

   vdt_decode u_decode (
      .cur_state  (state_ff),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .next_state (state_in),
      .emit       (emit)
   );

   assign req_tready = (count_ff <= CntW'(QDepth - 2));
   assign req_accept = req_tvalid && req_tready;
   assign last_accept = req_accept && req_tlast;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = data_ff[rd_ptr_ff];
   assign rsp_tlast  = last_ff[rd_ptr_ff];

   assign push_n      = req_accept ? emit.count : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);
   assign wr_ptr_in   = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in   = rsp_accept ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
   assign count_in    = count_ff + CntW'(push_n) - CntW'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) state_ff <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries are payload only; the count says which ones are live.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         data_ff[wr_ptr_ff] <= emit.byte0;
         last_ff[wr_ptr_ff] <= emit.last0;
      end
      if (push_n == 2'd2) begin
         data_ff[wr_ptr_next] <= emit.byte1;
         last_ff[wr_ptr_next] <= emit.last1;
      end
   end

   `VDT_ASSERT_SAME(a_queue_bound, 1'b1, count_ff <= CntW'(QDepth), "result queue overflow")
   `VDT_ASSERT_NEXT(a_last_gives_result, last_accept, count_ff != '0, "final word gave no result")
   `VDT_ASSERT_NEXT(a_last_flushes, last_accept, !state_ff.held_valid, "held byte not flushed")

endmodule

>>> tb/sv/tb_vietnamese_digraph_transcoder_top.sv
// Self-checking testbench for the Vietnamese digraph transcoder top level.
// Drives text words through the input stream and checks every result word against a
// typed row or a letter-plus-digit folding predictor; depends on vdt_pkg and the RTL only.
module tb_vietnamese_digraph_transcoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vdt_pkg::*;

   localparam int RandomWords = 650;
   localparam int StallStart  = 220;   // words taken before the long receiver hold-off
   localparam int StallCycles = 250;
   localparam int PausePoint  = 420;   // word index where the sender waits for a drained queue
   localparam int CalmFirst   = 470;
   localparam int CalmLast    = 600;
   localparam int IdlePercent = 7;
   localparam int DrainCycles = 8;
   localparam int QuietLimit  = 3000;
   localparam int ReportLimit = 10;

   localparam logic Typed     = 1'b1;
   localparam logic Predicted = 1'b0;

   // Lookup rows for the marked vowels, lowest byte is the mark of digit one.
   localparam logic [39:0] IMarks = {8'd183, 8'd182, 8'd181, 8'd175, 8'd174};
   localparam logic [39:0] OMarks = {8'd208, 8'd199, 8'd198, 8'd190, 8'd184};
   localparam logic [39:0] YMarks = {8'd248, 8'd222, 8'd221, 8'd216, 8'd215};

   localparam logic [63:0] Leads = {ChUpD, ChLowD, ChLowY, ChLowU,
                                    ChLowO, ChLowI, ChLowE, ChLowA};
   localparam logic [47:0] Bases = {BaseU7, BaseO6, BaseO7, BaseE6, BaseA6, BaseA8};
   localparam logic [47:0] BaseLetters = {ChLowU, ChLowO, ChLowO, ChLowE, ChLowA, ChLowA};
   localparam logic [47:0] BaseDigits  = {CharSeven, CharSix, CharSeven,
                                          CharSix, CharSix, CharEight};

   typedef struct packed {
      logic [7:0] text;
      logic       fin;
   } text_word_type;

   typedef struct packed {
      logic [7:0] text;
      logic       fin;
      logic       typed;
      logic [1:0] n;
      logic [7:0] e0;
      logic [7:0] e1;
   } plan_row_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;

   plan_row_type  plan[$];
   plan_row_type  cur_plan = '0;
   logic          calm     = 1'b0;

   // Predictor state: the one pending letter or base code.
   logic       held_valid   = 1'b0;
   logic [7:0] held_byte    = 8'd0;
   logic       held_is_base = 1'b0;

   text_word_type fresh_text[$];
   text_word_type pending_text[$];
   logic [7:0]    burst[$];

   int words_taken   = 0;
   int results_seen  = 0;
   int string_ends   = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;

   vietnamese_digraph_transcoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic logic vni_base(input logic [7:0] b);
      return b == BaseA8 || b == BaseA6 || b == BaseE6 ||
             b == BaseO7 || b == BaseO6 || b == BaseU7;
   endfunction

   function automatic logic vni_lead(input logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
         if (b == Leads[i*8 +: 8]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Folded code of a letter and its follower, zero when the pair means nothing.
   function automatic logic [7:0] vni_fold(input logic [7:0] letter, input logic [7:0] digit);
      logic [7:0] code;
      int k;
      code = 8'd0;
      k = int'(digit) - int'(CharOne);
      for (int i = 0; i < 6; i++) begin
         if (letter == BaseLetters[i*8 +: 8] && digit == BaseDigits[i*8 +: 8])
            code = Bases[i*8 +: 8];
      end
      if (letter == ChLowD && digit == CharNine) code = CodeD9;
      if (letter == ChUpD && digit == CharNine) code = CodeUpD9;
      if (code == 8'd0 && k >= 0 && k <= 4) begin
         case (letter)
            ChLowA: code = ToneA + 8'(k);
            ChLowE: code = ToneE + 8'(k);
            ChLowU: code = ToneU + 8'(k);
            ChLowI: code = IMarks[k*8 +: 8];
            ChLowO: code = OMarks[k*8 +: 8];
            ChLowY: code = YMarks[k*8 +: 8];
            default: code = 8'd0;
         endcase
      end
      return code;
   endfunction

   function automatic logic [7:0] CharThree();
      return CharOne + 8'd2;
   endfunction

   // Advances the pending byte by one text word and leaves its results in fresh_text.
   task automatic predict_text(input logic [7:0] b, input logic fin);
      logic       used;
      logic [7:0] code;
      used = 1'b0;
      fresh_text.delete();
      if (held_valid) begin
         code = vni_fold(held_byte, b);
         if (held_is_base && b >= CharOne && b <= CharFive) begin
            fresh_text.push_back({held_byte + (b - CharZero), 1'b0});
            held_valid = 1'b0;
            used = 1'b1;
         end else if (!held_is_base && code != 8'd0) begin
            if (vni_base(code)) begin
               held_byte = code;
               held_is_base = 1'b1;
            end else begin
               fresh_text.push_back({code, 1'b0});
               held_valid = 1'b0;
            end
            used = 1'b1;
         end else begin
            fresh_text.push_back({held_byte, 1'b0});
            held_valid = 1'b0;
         end
      end
      if (!used) begin
         if (vni_lead(b) || vni_base(b)) begin
            held_valid = 1'b1;
            held_byte = b;
            held_is_base = vni_base(b);
         end else begin
            fresh_text.push_back({b, 1'b0});
         end
      end
      if (fin) begin
         if (held_valid) begin
            fresh_text.push_back({held_byte, 1'b0});
            held_valid = 1'b0;
            held_is_base = 1'b0;
         end
         fresh_text[fresh_text.size() - 1].fin = 1'b1;
      end
   endtask

   task automatic plan_row(input logic [7:0] text, input logic fin, input logic typed,
                           input logic [1:0] n, input logic [7:0] e0, input logic [7:0] e1);
      plan.push_back({text, fin, typed, n, e0, e1});
   endtask

   // Random text mostly made of letter-plus-digit sequences, the rest plain bytes.
   task automatic draw_text(output logic [7:0] text, output logic fin);
      int pick;
      int j;
      if (burst.size() == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            j = $urandom_range(0, 7);
            burst.push_back(Leads[j*8 +: 8]);
            burst.push_back(CharZero + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1) burst.push_back(CharOne + 8'($urandom_range(0, 4)));
         end else if (pick < 55) begin
            j = $urandom_range(0, 5);
            burst.push_back(BaseLetters[j*8 +: 8]);
            burst.push_back(BaseDigits[j*8 +: 8]);
            burst.push_back(CharZero + 8'($urandom_range(0, 9)));
         end else if (pick < 65) begin
            j = $urandom_range(0, 5);
            burst.push_back(Bases[j*8 +: 8]);
            burst.push_back(CharZero + 8'($urandom_range(0, 9)));
         end else if (pick < 75) begin
            burst.push_back(($urandom_range(0, 1) == 1 ? 8'h61 : 8'h41) +
                            8'($urandom_range(0, 25)));
         end else begin
            burst.push_back(8'($urandom_range(0, 255)));
         end
      end
      text = burst.pop_front();
      fin = ($urandom_range(0, 15) == 0);
   endtask

   task automatic flag_mismatch(input string what, input text_word_type want,
                                input text_word_type got);
      mismatches++;
      if (mismatches <= ReportLimit)
         $display("MISMATCH %s: expected byte %0d last %0d, got byte %0d last %0d",
                  what, want.text, want.fin, got.text, got.fin);
   endtask

   // Single process for both handshakes, so predictions always land before checks.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            words_taken++;
            if (req_tlast) string_ends++;
            predict_text(req_tdata, req_tlast);
            if (cur_plan.typed) begin
               if (cur_plan.n > 0)
                  pending_text.push_back({cur_plan.e0, cur_plan.fin && cur_plan.n == 2'd1});
               if (cur_plan.n > 1) pending_text.push_back({cur_plan.e1, cur_plan.fin});
            end else begin
               foreach (fresh_text[i]) pending_text.push_back(fresh_text[i]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            results_seen++;
            if (pending_text.size() == 0) begin
               flag_mismatch("unexpected word", '0, {rsp_tdata, rsp_tlast});
            end else if (pending_text[0] != {rsp_tdata, rsp_tlast}) begin
               flag_mismatch("result word", pending_text[0], {rsp_tdata, rsp_tlast});
               void'(pending_text.pop_front());
            end else begin
               void'(pending_text.pop_front());
            end
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("Timeout: no word moved for %0d cycles", QuietLimit);
            $display("vietnamese_digraph_transcoder_top test failed");
            $finish;
         end
      end
   end

   // Receiver: rare random stalls, one long hold-off, none during the calm window.
   initial begin
      logic stalled;
      stalled = 1'b0;
      forever begin
         @(posedge clock);
         if (!stalled && words_taken >= StallStart) begin
            stalled = 1'b1;
            rsp_tready <= 1'b0;
            repeat (StallCycles) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
      end
   end

   initial begin
      logic [7:0] text;
      logic       fin;
      int         total;
      int         directed;

      plan_row(8'h00, 1'b0, Typed, 2'd1, 8'h00, 8'h00);
      plan_row(8'hff, 1'b1, Typed, 2'd1, 8'hff, 8'h00);
      // A base pair takes a tone digit on top.
      plan_row(ChLowA, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharEight, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharFive, 1'b0, Typed, 2'd1, BaseA8 + 8'd5, 8'h00);
      // A base pair on the final word is flushed as it stands.
      plan_row(ChLowO, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharSix, 1'b1, Typed, 2'd1, BaseO6, 8'h00);
      plan_row(ChLowI, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharThree(), 1'b0, Typed, 2'd1, 8'd181, 8'h00);
      plan_row(ChLowY, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharFive, 1'b0, Typed, 2'd1, 8'd248, 8'h00);
      plan_row(ChUpD, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharNine, 1'b0, Typed, 2'd1, CodeUpD9, 8'h00);
      plan_row(ChLowD, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharNine, 1'b0, Typed, 2'd1, CodeD9, 8'h00);
      // A letter with an unlisted follower goes out plain, and the follower is held.
      plan_row(ChLowI, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(ChLowA, 1'b0, Typed, 2'd1, ChLowI, 8'h00);
      plan_row(CharZero, 1'b0, Typed, 2'd2, ChLowA, CharZero);
      plan_row(BaseE6, 1'b1, Typed, 2'd1, BaseE6, 8'h00);
      plan_row(BaseU7, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharOne, 1'b0, Typed, 2'd1, BaseU7 + 8'd1, 8'h00);
      // A raw base followed by a digit outside one to five stays separate.
      plan_row(BaseA8, 1'b0, Typed, 2'd0, 8'h00, 8'h00);
      plan_row(CharSix, 1'b0, Typed, 2'd2, BaseA8, CharSix);
      plan_row(ChLowO, 1'b0, Predicted, 2'd0, 8'h00, 8'h00);
      plan_row(CharSeven, 1'b0, Predicted, 2'd0, 8'h00, 8'h00);
      plan_row(8'h78, 1'b1, Predicted, 2'd0, 8'h00, 8'h00);
      directed = plan.size();
      total = directed + RandomWords;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < total; k++) begin
         if (k == PausePoint) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_text.size() != 0);
         end
         while (!(k >= CalmFirst && k < CalmLast) && $urandom_range(0, 99) < IdlePercent) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         if (k < directed) begin
            text = plan[k].text;
            fin = plan[k].fin;
            cur_plan <= plan[k];
         end else begin
            draw_text(text, fin);
            cur_plan <= {text, fin, Predicted, 2'd0, 8'h00, 8'h00};
         end
         calm <= (k >= CalmFirst && k < CalmLast);
         req_tvalid <= 1'b1;
         req_tdata <= text;
         req_tlast <= fin;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      calm <= 1'b0;

      do @(posedge clock); while (pending_text.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      if (pending_text.size() != 0) begin
         mismatches += pending_text.size();
         $display("%0d expected result words never arrived", pending_text.size());
      end

      $display("Covered %0d text words (%0d directed) across %0d strings, %0d result words.",
               words_taken, directed, string_ends, results_seen);
      $display("Run included a long output hold-off, a drained pause and a stall-free %s%0d",
               "stretch; mismatches: ", mismatches);
      if (mismatches == 0) begin
         $display("vietnamese_digraph_transcoder_top test passed");
      end else begin
         $display("vietnamese_digraph_transcoder_top test failed");
      end
      $finish;
   end

endmodule
